// File: hdl/trial_division_prime_test_unit_assert.svh
// Assertion macros shared by the trial division prime test RTL.
// No dependencies; files that check their own logic include this header.
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TDPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tdpt assertion failed");

// next-cycle implication
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tdpt assertion failed");

`else

`define TDPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/tdpt_pkg.sv
// Types and constants for the trial division prime test unit.
// No dependencies.
package tdpt_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} tdpt_state_t;

	// sequencer strobes
	typedef struct packed {
		logic in_stall;
		logic div_start;
		logic out_load;
	} tdpt_ctrl_t;

endpackage

// File: hdl/tdpt_rem_unit.sv
// Iterative remainder unit: restoring shift-subtract, one dividend bit per cycle.
// Depends on trial_division_prime_test_unit_assert.svh.
`include "trial_division_prime_test_unit_assert.svh"

module tdpt_rem_unit #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

	`TDPT_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q)
	`TDPT_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, !busy_q)
	`TDPT_ASSERT_NEXT(a_run_holds, clk, arst_n, busy_q && (cnt_q != '0) && !start, busy_q)

endmodule

// File: hdl/trial_division_prime_test_unit.sv
// Top level of the trial division prime test unit: sequencer, candidate and
// square registers, output register. Depends on tdpt_pkg and tdpt_rem_unit.
//
// Tests one signed VALUE_WIDTH-bit word for primality and returns one prime_flag
// bit per input. Negative values, 0 to 3 and even values are settled in the
// accept cycle and go through ST_FINISH to the output register. Odd values
// of 5 and up are tried against odd divisors 3, 5, 7 and on while d*d <= value;
// each candidate passes through ST_CHECK and one shared shift-subtract remainder
// unit in ST_DIV, so the work for an item grows with the number of candidates
// tried: a composite stops at its smallest odd factor, a prime near
// 2^(VALUE_WIDTH-1) tries about 2^((VALUE_WIDTH-1)/2) / 2 candidates. in_stall
// stays high while an item is in work; a finished word waits in the output
// register and a new input is taken meanwhile.
`include "trial_division_prime_test_unit_assert.svh"

module trial_division_prime_test_unit
	import tdpt_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          prime_flag
);

	localparam int W  = VALUE_WIDTH;
	localparam int SW = VALUE_WIDTH + 1;

	tdpt_state_t      state_q, state_d;
	tdpt_ctrl_t       ctrl;
	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [SW-1:0]    sq_q;
	logic             verdict_q;
	logic             out_valid_q;
	logic             prime_flag_q;
	logic             early;
	logic             early_flag;
	logic             sq_over;
	logic             div_busy;
	logic             div_done;
	logic [W-1:0]     div_rem;
	logic [W-1:0]     raw;

	assign raw = value;

	// sign set, below 4 or even: no division needed
	assign early      = raw[W-1] || (raw[W-1:2] == '0) || !raw[0];
	assign early_flag = !raw[W-1] && (raw[W-1:1] == (W-1)'(1));
	assign sq_over    = sq_q > {1'b0, n_q};

	tdpt_rem_unit #(
		.W(W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = early ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sq_over ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (div_rem == '0) ? ST_FINISH : ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.in_stall  = (state_q != ST_IDLE);
		ctrl.div_start = (state_q == ST_CHECK) && !sq_over;
		ctrl.out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			prime_flag_q <= verdict_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_q       <= raw;
					d_q       <= W'(3);
					sq_q      <= SW'(9);
					verdict_q <= early_flag;
				end
			end
			ST_CHECK: begin
				if (sq_over) begin
					verdict_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					// (d+2)^2 = d^2 + 4d + 4
					verdict_q <= 1'b0;
					d_q       <= d_q + W'(2);
					sq_q      <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall   = ctrl.in_stall;
	assign out_valid  = out_valid_q;
	assign prime_flag = prime_flag_q;

	`TDPT_ASSERT_NOW(a_start_free, clk, arst_n, ctrl.div_start, !div_busy)
	`TDPT_ASSERT_NOW(a_div_odd, clk, arst_n, state_q == ST_CHECK || state_q == ST_DIV, d_q[0])
	`TDPT_ASSERT_NOW(a_sq_match, clk, arst_n, state_q == ST_CHECK, sq_q == SW'(d_q * d_q))
	`TDPT_ASSERT_NEXT(a_finish_out, clk, arst_n, ctrl.out_load, out_valid_q && state_q == ST_IDLE)

endmodule
